FILE: rtl/fwdf_pkg.sv
package fwdf_pkg;

    localparam int ValueW = 32;
    localparam int ModeW  = 2;
    localparam int CharW  = 8;
    localparam int MaxDigits = 10;
    localparam int DigIdxW = $clog2(MaxDigits);

    // width mode codes
    localparam logic [ModeW-1:0] MODE_8  = 2'd0;
    localparam logic [ModeW-1:0] MODE_16 = 2'd1;
    localparam logic [ModeW-1:0] MODE_32 = 2'd2;

    // ASCII characters
    localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
    localparam logic [CharW-1:0] CH_CR    = 8'h0D;
    localparam logic [CharW-1:0] CH_LF    = 8'h0A;
    localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
    localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;

    // reciprocal of ten, exact for any 32-bit dividend with a shift of 35
    localparam logic [ValueW-1:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int RecipShift = 35;

    // output character select codes
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_SIGN  = 2'd0;
    localparam t_sel SEL_DIGIT = 2'd1;
    localparam t_sel SEL_CR    = 2'd2;
    localparam t_sel SEL_LF    = 2'd3;

    typedef struct packed {
        logic                 load;
        logic                 step;
        logic                 out_load;
        t_sel                 sel;
        logic [DigIdxW-1:0]   idx;
    } t_cmd;

    typedef struct packed {
        logic [DigIdxW-1:0]   places;
        logic                 sgn;
    } t_status;

endpackage

FILE: rtl/fixed_width_decimal_formatter.sv
// Converts one binary value into a fixed-width ASCII decimal record sent one
// character per output item: an optional sign ('+' or '-', signed mode only),
// 3, 5 or 10 zero-padded digits for the 8-, 16- and 32-bit modes (mode 3 acts
// as 32-bit), then CR and LF, with tlast on the LF. The most negative value
// of each width prints its true magnitude. An item is accepted, then its digits
// are worked out one per cycle in the shared divide-by-ten unit (a reciprocal
// multiply), then the characters go out one per cycle while the sink is ready.
// A new input is taken once the LF has been loaded into the output register.
module fixed_width_decimal_formatter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] value
    input  logic [2:0]   s_axis_tuser,   // [1:0] width_mode, [2] is_signed
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // [7:0] char_out
    output logic         m_axis_tlast    // last
);
    import fwdf_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    fwdf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    fwdf_datapath u_datapath (
        .i_clk    (i_clk),
        .i_value  (s_axis_tdata),
        .i_mode   (s_axis_tuser[1:0]),
        .i_sgn    (s_axis_tuser[2]),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_char   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule

FILE: rtl/fwdf_datapath.sv
module fwdf_datapath (
    input  logic                          i_clk,
    input  logic [fwdf_pkg::ValueW-1:0]   i_value,
    input  logic [fwdf_pkg::ModeW-1:0]    i_mode,
    input  logic                          i_sgn,
    input  fwdf_pkg::t_cmd                i_cmd,
    output fwdf_pkg::t_status             o_status,
    output logic [fwdf_pkg::CharW-1:0]    o_char,
    output logic                          o_last
);
    import fwdf_pkg::*;

    logic [ValueW-1:0]         r_mag, n_mag;
    logic [3:0]                r_dig [MaxDigits];
    logic                      r_neg;
    logic                      r_sgn;
    logic [DigIdxW-1:0]        r_places;
    logic [CharW-1:0]          r_char, n_char;
    logic                      r_last;

    logic [ValueW-1:0]         w_mask;
    logic [ValueW-1:0]         w_masked;
    logic                      w_sign_bit;
    logic                      w_neg;
    logic [DigIdxW-1:0]        w_places;
    logic [2*ValueW-1:0]       w_prod;
    logic [ValueW-1:0]         w_quot;
    logic [ValueW-1:0]         w_rem;

    always_comb begin
        unique case (i_mode)
            MODE_8: begin
                w_mask     = 32'h0000_00FF;
                w_sign_bit = i_value[7];
                w_places   = DigIdxW'(3);
            end
            MODE_16: begin
                w_mask     = 32'h0000_FFFF;
                w_sign_bit = i_value[15];
                w_places   = DigIdxW'(5);
            end
            default: begin
                w_mask     = 32'hFFFF_FFFF;
                w_sign_bit = i_value[31];
                w_places   = DigIdxW'(MaxDigits);
            end
        endcase
        w_masked = i_value & w_mask;
        w_neg    = i_sgn & w_sign_bit;
    end

    // one decimal digit per step: quotient by reciprocal, remainder by shift-add
    assign w_prod = r_mag * RECIP10;
    assign w_quot = ValueW'(w_prod >> RecipShift);
    assign w_rem  = r_mag - ((w_quot << 3) + (w_quot << 1));

    always_comb begin
        n_mag = r_mag;
        if (i_cmd.load) begin
            n_mag = w_neg ? ((32'd0 - w_masked) & w_mask) : w_masked;
        end else if (i_cmd.step) begin
            n_mag = w_quot;
        end
    end

    always_comb begin
        case (i_cmd.sel)
            SEL_SIGN:  n_char = r_neg ? CH_MINUS : CH_PLUS;
            SEL_DIGIT: n_char = CH_ZERO + {4'd0, r_dig[i_cmd.idx]};
            SEL_CR:    n_char = CH_CR;
            default:   n_char = CH_LF;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        if (i_cmd.load) begin
            r_neg    <= w_neg;
            r_sgn    <= i_sgn;
            r_places <= w_places;
        end
        if (i_cmd.step) begin
            r_dig[i_cmd.idx] <= w_rem[3:0];
        end
        if (i_cmd.out_load) begin
            r_char <= n_char;
            r_last <= (i_cmd.sel == SEL_LF);
        end
    end

    assign o_status.places = r_places;
    assign o_status.sgn    = r_sgn;
    assign o_char          = r_char;
    assign o_last          = r_last;

endmodule

FILE: rtl/fwdf_ctrl.sv
module fwdf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  fwdf_pkg::t_status    i_status,
    output fwdf_pkg::t_cmd       o_cmd
);
    import fwdf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SIGN = 3'd2;
    localparam logic [2:0] ST_DIG  = 3'd3;
    localparam logic [2:0] ST_CR   = 3'd4;
    localparam logic [2:0] ST_LF   = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [DigIdxW-1:0]  r_cnt, n_cnt;
    logic                r_ovalid, n_ovalid;
    logic                w_slot;
    logic [DigIdxW-1:0]  w_top;

    assign w_slot = !r_ovalid || i_out_ready;
    assign w_top  = i_status.places - DigIdxW'(1);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd.load     = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.out_load = 1'b0;
        o_cmd.sel      = SEL_DIGIT;
        o_cmd.idx      = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (r_cnt == w_top) begin
                    n_state = i_status.sgn ? ST_SIGN : ST_DIG;
                end else begin
                    n_cnt = r_cnt + DigIdxW'(1);
                end
            end
            ST_SIGN: begin
                o_cmd.sel = SEL_SIGN;
                if (w_slot) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_DIG;
                end
            end
            ST_DIG: begin
                // most significant digit first
                if (w_slot) begin
                    o_cmd.out_load = 1'b1;
                    if (r_cnt == '0) begin
                        n_state = ST_CR;
                    end else begin
                        n_cnt = r_cnt - DigIdxW'(1);
                    end
                end
            end
            ST_CR: begin
                o_cmd.sel = SEL_CR;
                if (w_slot) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_LF;
                end
            end
            ST_LF: begin
                o_cmd.sel = SEL_LF;
                if (w_slot) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (o_cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> w_slot)
        else $error("output register overwritten while still valid");

    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt < i_status.places))
        else $error("digit counter past record width");

    a_dig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIG) |-> (r_cnt < i_status.places))
        else $error("digit index past record width");

    a_lf_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && o_cmd.sel == SEL_LF) |=> (r_state == ST_IDLE))
        else $error("record did not end after LF");

endmodule

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fwdf_pkg::*;

    localparam int IdleLimit  = 3000;
    localparam int DrainWait  = 40;
    localparam int RandValues = 200;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_exp;

    class record_scoreboard;
        t_char_exp pending[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void push_char(logic [7:0] ch, logic last);
            t_char_exp c;
            c.ch   = ch;
            c.last = last;
            pending.push_back(c);
        endfunction

        // Build the whole expected record for one accepted value.
        function void note_value(logic [31:0] value, logic [1:0] mode, logic sgn);
            int          places;
            logic [31:0] mask;
            logic [31:0] sign_bit;
            logic [31:0] mag;
            logic        neg;
            logic [7:0]  digs [10];
            case (mode)
                MODE_8: begin
                    places = 3;
                    mask = 32'h0000_00FF;
                    sign_bit = 32'h0000_0080;
                end
                MODE_16: begin
                    places = 5;
                    mask = 32'h0000_FFFF;
                    sign_bit = 32'h0000_8000;
                end
                default: begin
                    places = 10;
                    mask = 32'hFFFF_FFFF;
                    sign_bit = 32'h8000_0000;
                end
            endcase
            mag = value & mask;
            neg = sgn && ((mag & sign_bit) != 0);
            // most negative value wraps to its own pattern, read unsigned
            if (neg) mag = (~mag + 32'd1) & mask;
            if (sgn) push_char(neg ? CH_MINUS : CH_PLUS, 1'b0);
            for (int i = places - 1; i >= 0; i--) begin
                digs[i] = CH_ZERO + 8'(mag % 32'd10);
                mag = mag / 32'd10;
            end
            for (int i = 0; i < places; i++) push_char(digs[i], 1'b0);
            push_char(CH_CR, 1'b0);
            push_char(CH_LF, 1'b1);
        endfunction

        task check_char(logic [7:0] ch, logic last);
            t_char_exp want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h last %0b", ch, last));
            end else begin
                want = pending.pop_front();
                if (ch !== want.ch)
                    report_mismatch($sformatf("char 0x%02h, want 0x%02h", ch, want.ch));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", last, want.last));
            end
        endtask

        task check_drained();
            if (pending.size() != 0)
                report_mismatch($sformatf("%0d chars never came", pending.size()));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] value
    logic [2:0]  s_axis_tuser;   // [1:0] width_mode, [2] is_signed
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] char_out
    logic        m_axis_tlast;

    record_scoreboard sb = new();

    int burst_left;
    int rx_left;
    int rx_style;
    int idle_cycles;

    fixed_width_decimal_formatter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one value; hold it until taken, then maybe end the burst.
    task send_value(logic [31:0] value, logic [1:0] mode, logic sgn);
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = value;
        s_axis_tuser  = {sgn, mode};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_value(value, mode, sgn);
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
    endtask

    // Receiver: the ready pattern switches between five randomly chosen styles.
    initial begin
        m_axis_tready = 1'b0;
        rx_left = 0;
        rx_style = 0;
        forever begin
            @(negedge i_clk);
            if (rx_left == 0) begin
                rx_style = $urandom_range(0, 4);
                rx_left = $urandom_range(16, 80);
            end
            case (rx_style)
                0: m_axis_tready = 1'b1;
                1: m_axis_tready = 1'($urandom_range(0, 1));
                2: m_axis_tready = ($urandom_range(0, 3) == 0);
                3: m_axis_tready = (rx_left % 6) < 3;
                default: m_axis_tready = (rx_left < 8);
            endcase
            rx_left--;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_char(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] v;
        logic [1:0]  m;
        idle_cycles   = 0;
        burst_left    = $urandom_range(1, 30);
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes of each width, signed and unsigned
        send_value(32'h0000_0000, MODE_8, 1'b0);
        send_value(32'h0000_00FF, MODE_8, 1'b0);
        send_value(32'hFFFF_FF7B, MODE_8, 1'b0);   // high bits ignored
        send_value(32'h0000_0080, MODE_8, 1'b1);   // most negative
        send_value(32'h0000_007F, MODE_8, 1'b1);
        send_value(32'hFFFF_FF00, MODE_8, 1'b1);   // signed zero
        send_value(32'h0000_00FF, MODE_8, 1'b1);
        send_value(32'h0000_0000, MODE_16, 1'b0);
        send_value(32'hFFFF_FFFF, MODE_16, 1'b0);
        send_value(32'h0000_8000, MODE_16, 1'b1);
        send_value(32'h0001_7FFF, MODE_16, 1'b1);
        send_value(32'h0000_FFFF, MODE_16, 1'b1);
        send_value(32'h0000_0000, MODE_16, 1'b1);
        send_value(32'h0000_0000, MODE_32, 1'b0);
        send_value(32'hFFFF_FFFF, MODE_32, 1'b0);
        send_value(32'h8000_0000, MODE_32, 1'b1);
        send_value(32'h7FFF_FFFF, MODE_32, 1'b1);
        send_value(32'hFFFF_FFFF, MODE_32, 1'b1);
        send_value(32'h0000_0000, MODE_32, 1'b1);
        send_value(32'hFFFF_FFFF, 2'd3, 1'b0);     // unused mode acts as 32-bit
        send_value(32'h8000_0000, 2'd3, 1'b1);

        for (int n = 0; n < RandValues; n++) begin
            v = $urandom;
            case ($urandom_range(0, 7))
                0: v = 32'h7FFF_FFFF + 32'($urandom_range(0, 2));
                1: v[15:0] = 16'h7FFF + 16'($urandom_range(0, 2));
                2: v[7:0] = 8'h7F + 8'($urandom_range(0, 2));
                3: v = $urandom_range(0, 20);
                default: ;
            endcase
            m = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            send_value(v, m, 1'($urandom_range(0, 1)));
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/fwdf_pkg.sv
rtl/fwdf_datapath.sv
rtl/fwdf_ctrl.sv
rtl/fixed_width_decimal_formatter.sv
dv/tb_top.sv
